>>> hw/rtl/luma_gamma_correction_defines.svh
// ----------------------------------------------------------------------------
// Luma gamma correction - assertion macros
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LUMA_GAMMA_CORRECTION_DEFINES_SVH
`define LUMA_GAMMA_CORRECTION_DEFINES_SVH

`ifndef SYNTHESIS
// consequent holds in the same cycle as the antecedent
`define LGC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// consequent holds in the cycle after the antecedent
`define LGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LGC_ASSERT_SAME(label, ante, cons, msg)
`define LGC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> hw/rtl/lgc_pkg.sv
// ----------------------------------------------------------------------------
// Luma gamma correction - package
// Fixed widths, payload structs and the exp2 root table generator.
// ----------------------------------------------------------------------------
package lgc_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 16;

  // log2 / exp2 work in Q1.30
  localparam int unsigned LOG_FB  = 30;
  localparam int unsigned M_W     = LOG_FB + 1;
  // position of the leading one of luminance (at most 32 bits wide)
  localparam int unsigned POS_W   = 5;
  localparam int unsigned IP_W    = POS_W + 2;
  // |log2| < 25 * 2^30
  localparam int unsigned LMAG_W  = 35;
  localparam int unsigned GAMMA_W = 16;
  localparam int unsigned GAMMA_FB = 12;
  localparam int unsigned EMAG_W  = LMAG_W + GAMMA_W - GAMMA_FB;
  localparam int unsigned EINT_W  = EMAG_W - LOG_FB;
  localparam int unsigned N_W     = EINT_W + 2;

  localparam logic [GAMMA_W-1:0] GAMMA_RST = 16'd4506;
  localparam logic [7:0]         GRAY_MAX  = 8'd255;
  // 2^8 and up always saturates
  localparam logic signed [N_W-1:0] N_CLIP = 11'sd8;
  localparam logic [M_W-1:0]     Q30_ONE   = M_W'(1) << LOG_FB;

  typedef struct packed {
    logic             zero;
    logic [POS_W-1:0] pos;
    logic [M_W-1:0]   m;
  } norm_t;

  typedef struct packed {
    logic              zero;
    logic              lneg;
    logic [LMAG_W-1:0] lmag;
  } log_t;

  typedef struct packed {
    logic [7:0] gray_level;
    logic       was_clipped;
  } res_t;

  function automatic logic [63:0] lgc_isqrt(logic [63:0] a);
    logic [63:0] r;
    logic [63:0] rem;
    logic [63:0] bitv;
    r   = '0;
    rem = a;
    for (int k = 31; k >= 0; k--) begin
      bitv = 64'd1 << (2 * k);
      if (rem >= r + bitv) begin
        rem = rem - (r + bitv);
        r   = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // 2^(2^-i) in Q1.30, by repeated square roots of 2
  function automatic logic [63:0] lgc_root(int unsigned i);
    logic [63:0] root;
    root = 64'd1 << (LOG_FB + 1);
    for (int unsigned j = 1; j <= LOG_FB; j++) begin
      if (j <= i) begin
        root = lgc_isqrt(root << LOG_FB);
      end
    end
    return root;
  endfunction

endpackage

>>> hw/rtl/lgc_pix_if.sv
// ----------------------------------------------------------------------------
// Luma gamma correction - pixel channel
// One BGR pixel per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lgc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, blue, green, red, input ready);
  modport sink   (input valid, blue, green, red, output ready);
endinterface

>>> hw/rtl/lgc_res_if.sv
// ----------------------------------------------------------------------------
// Luma gamma correction - result channel
// One gray level and clip flag per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lgc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] gray_level;
  logic       was_clipped;

  modport source (output valid, gray_level, was_clipped, input ready);
  modport sink   (input valid, gray_level, was_clipped, output ready);
endinterface

>>> hw/rtl/lgc_front.sv
// ----------------------------------------------------------------------------
// Luma gamma correction - front end
// Weighted luminance sum, leading-one search and normalization to Q1.30.
// Three register stages.
// ----------------------------------------------------------------------------
module lgc_front #(
  parameter int unsigned FRACTION_BITS = lgc_pkg::FRACTION_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  lgc_pix_if.sink        pix_i,
  output logic           valid_o,
  output lgc_pkg::norm_t norm_o
);
  import lgc_pkg::*;

  localparam int unsigned XW = FRACTION_BITS + 8;
  localparam logic [63:0] ONE_F = 64'd1 << FRACTION_BITS;
  localparam logic [63:0] W_RED_L = (64'd3 * ONE_F + 64'd5) / 64'd10;
  localparam logic [63:0] W_GREEN_L = (64'd59 * ONE_F + 64'd50) / 64'd100;
  localparam logic [XW-1:0] W_RED = XW'(W_RED_L);
  localparam logic [XW-1:0] W_GREEN = XW'(W_GREEN_L);
  localparam logic [XW-1:0] W_BLUE = XW'(ONE_F - W_RED_L - W_GREEN_L);

  logic          v1_q, v2_q, v3_q;
  logic [XW-1:0] x1_d, x1_q, x2_q;
  logic [POS_W-1:0] pos_d, pos_q;
  logic          zero_q;
  logic [XW+LOG_FB-1:0] shifted;
  norm_t         norm_d, norm_q;

  assign pix_i.ready = en_i;

  assign x1_d = XW'(pix_i.red) * W_RED + XW'(pix_i.green) * W_GREEN
              + XW'(pix_i.blue) * W_BLUE;

  always_comb begin
    pos_d = '0;
    for (int k = 0; k < XW; k++) begin
      if (x1_q[k]) begin
        pos_d = POS_W'(k);
      end
    end
  end

  // x * 2^(30 - pos), truncated when pos exceeds 30
  assign shifted = {x2_q, LOG_FB'(0)} >> pos_q;

  always_comb begin
    norm_d.zero = zero_q;
    norm_d.pos  = pos_q;
    norm_d.m    = shifted[M_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= pix_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= x1_d;
      x2_q   <= x1_q;
      zero_q <= (x1_q == '0);
      pos_q  <= pos_d;
      norm_q <= norm_d;
    end
  end

  assign valid_o = v3_q;
  assign norm_o  = norm_q;

endmodule

>>> hw/rtl/lgc_log2.sv
// ----------------------------------------------------------------------------
// Luma gamma correction - log2
// Bit-serial log2 by repeated squaring, one fraction bit per stage,
// then the signed log as sign and magnitude. LOG_FB + 1 register stages.
// ----------------------------------------------------------------------------
module lgc_log2 #(
  parameter int unsigned FRACTION_BITS = lgc_pkg::FRACTION_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  lgc_pkg::norm_t norm_i,
  output logic           valid_o,
  output lgc_pkg::log_t  log_o
);
  import lgc_pkg::*;

  logic              v_s    [LOG_FB+1];
  logic              zero_s [LOG_FB+1];
  logic [POS_W-1:0]  pos_s  [LOG_FB+1];
  logic [M_W-1:0]    m_s    [LOG_FB+1];
  logic [LOG_FB-1:0] lf_s   [LOG_FB+1];

  assign v_s[0]    = valid_i;
  assign zero_s[0] = norm_i.zero;
  assign pos_s[0]  = norm_i.pos;
  assign m_s[0]    = norm_i.m;
  assign lf_s[0]   = '0;

  for (genvar i = 0; i < LOG_FB; i++) begin : g_sq
    logic [2*M_W-1:0] sq;
    logic [M_W:0]     sq_hi;
    logic [M_W-1:0]   m_d;
    logic             lbit;

    always_comb begin
      sq    = (2*M_W)'(m_s[i]) * (2*M_W)'(m_s[i]);
      sq_hi = sq[LOG_FB+M_W:LOG_FB];
      // square reached 2.0: renormalize and emit a one
      if (sq_hi[M_W]) begin
        m_d  = sq_hi[M_W:1];
        lbit = 1'b1;
      end else begin
        m_d  = sq_hi[M_W-1:0];
        lbit = 1'b0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[i+1] <= 1'b0;
      end else if (en_i) begin
        v_s[i+1] <= v_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_s[i+1] <= zero_s[i];
        pos_s[i+1]  <= pos_s[i];
        m_s[i+1]    <= m_d;
        lf_s[i+1]   <= {lf_s[i][LOG_FB-2:0], lbit};
      end
    end
  end

  logic signed [IP_W-1:0] ip;
  logic [IP_W-1:0]        ip_mag;
  logic [LMAG_W-1:0]      ip_sh;
  log_t                   log_d, log_q;
  logic                   v_q;

  always_comb begin
    ip     = IP_W'(pos_s[LOG_FB]) - IP_W'(FRACTION_BITS);
    ip_mag = ip[IP_W-1] ? IP_W'(-ip) : IP_W'(ip);
    ip_sh  = LMAG_W'(ip_mag) << LOG_FB;
    log_d.zero = zero_s[LOG_FB];
    log_d.lneg = ip[IP_W-1];
    if (ip[IP_W-1]) begin
      log_d.lmag = ip_sh - LMAG_W'(lf_s[LOG_FB]);
    end else begin
      log_d.lmag = ip_sh | LMAG_W'(lf_s[LOG_FB]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= v_s[LOG_FB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      log_q <= log_d;
    end
  end

  assign valid_o = v_q;
  assign log_o   = log_q;

endmodule

>>> hw/rtl/lgc_exp2.sv
// ----------------------------------------------------------------------------
// Luma gamma correction - power and exp2
// Exponent product with gamma, floor split, bit-serial exp2 over a constant
// root table (one multiply per stage), final shift and saturation.
// LOG_FB + 3 register stages.
// ----------------------------------------------------------------------------
module lgc_exp2 #(
  parameter int unsigned FRACTION_BITS = lgc_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [lgc_pkg::GAMMA_W-1:0] gamma_i,
  input  logic                        valid_i,
  input  lgc_pkg::log_t               log_i,
  output logic                        valid_o,
  output lgc_pkg::res_t               res_o
);
  import lgc_pkg::*;

  localparam logic [POS_W:0] FB6 = (POS_W+1)'(FRACTION_BITS);
  localparam int unsigned PW = LMAG_W + GAMMA_W;

  // stage 1: |log2| * gamma, truncated
  logic [PW-1:0]     prod;
  logic [EMAG_W-1:0] emag_q;
  logic              lneg_q, zero1_q, v1_q;

  assign prod = PW'(log_i.lmag) * PW'(gamma_i);

  // stage 2: floor integer part and non-negative fraction
  logic [EINT_W-1:0]        ei;
  logic [LOG_FB-1:0]        ef;
  logic signed [N_W-1:0]    ni, n_d;
  logic [LOG_FB-1:0]        ef_d;

  always_comb begin
    ei   = emag_q[EMAG_W-1:LOG_FB];
    ef   = emag_q[LOG_FB-1:0];
    ni   = N_W'(ei);
    n_d  = ni;
    ef_d = ef;
    if (lneg_q) begin
      if (ef == '0) begin
        n_d = -ni;
      end else begin
        n_d  = -ni - N_W'(1);
        ef_d = ~ef + LOG_FB'(1);
      end
    end
  end

  logic                  v_s    [LOG_FB+1];
  logic                  zero_s [LOG_FB+1];
  logic signed [N_W-1:0] n_s    [LOG_FB+1];
  logic [LOG_FB-1:0]     ef_s   [LOG_FB+1];
  logic [M_W-1:0]        acc_s  [LOG_FB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v_s[0] <= 1'b0;
    end else if (en_i) begin
      v1_q   <= valid_i;
      v_s[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      emag_q    <= prod[PW-1:GAMMA_FB];
      lneg_q    <= log_i.lneg;
      zero1_q   <= log_i.zero;
      zero_s[0] <= zero1_q;
      n_s[0]    <= n_d;
      ef_s[0]   <= ef_d;
    end
  end

  assign acc_s[0] = Q30_ONE;

  for (genvar i = 0; i < LOG_FB; i++) begin : g_mul
    localparam logic [M_W-1:0] ROOT = M_W'(lgc_root(i + 1));
    logic [2*M_W-1:0] mp;
    logic [M_W-1:0]   acc_d;

    always_comb begin
      mp = (2*M_W)'(acc_s[i]) * (2*M_W)'(ROOT);
      acc_d = ef_s[i][LOG_FB-1-i] ? mp[LOG_FB+M_W-1:LOG_FB] : acc_s[i];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[i+1] <= 1'b0;
      end else if (en_i) begin
        v_s[i+1] <= v_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_s[i+1] <= zero_s[i];
        n_s[i+1]    <= n_s[i];
        ef_s[i+1]   <= ef_s[i];
        acc_s[i+1]  <= acc_d;
      end
    end
  end

  // final stage: value = acc * 2^(n - 30), kept to FRACTION_BITS fraction bits
  logic signed [N_W:0] tt;
  logic [POS_W-1:0]    sh, lo;
  logic [M_W-1:0]      acc, below;
  logic [7:0]          intv;
  logic                frac_nz;
  res_t                res_d, res_q;
  logic                vf_q;

  always_comb begin
    acc = acc_s[LOG_FB];
    tt  = (N_W+1)'(LOG_FB) - (N_W+1)'(n_s[LOG_FB]);
    // beyond 31 the integer part is zero anyway
    sh  = (tt > (N_W+1)'(M_W)) ? POS_W'(M_W) : tt[POS_W-1:0];
    lo  = ({1'b0, sh} >= FB6) ? POS_W'({1'b0, sh} - FB6) : '0;
    below   = acc & ((M_W'(1) << sh) - M_W'(1));
    frac_nz = |(below >> lo);
    intv    = 8'(acc >> sh);
    priority if (zero_s[LOG_FB]) begin
      res_d.gray_level  = '0;
      res_d.was_clipped = 1'b0;
    end else if (n_s[LOG_FB] >= N_CLIP) begin
      res_d.gray_level  = GRAY_MAX;
      res_d.was_clipped = 1'b1;
    end else if (intv == GRAY_MAX && frac_nz) begin
      res_d.gray_level  = GRAY_MAX;
      res_d.was_clipped = 1'b1;
    end else begin
      res_d.gray_level  = intv;
      res_d.was_clipped = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= v_s[LOG_FB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = vf_q;
  assign res_o   = res_q;

endmodule

>>> hw/rtl/lgc_skid.sv
// ----------------------------------------------------------------------------
// Luma gamma correction - output buffer
// Output register plus one skid entry; the pipeline advances while the
// skid entry is free, so ready never depends combinationally on the sink.
// ----------------------------------------------------------------------------
module lgc_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  input  lgc_pkg::res_t res_i,
  output logic          ready_o,
  lgc_res_if.source     res_o
);
  import lgc_pkg::*;

  logic out_v_q, out_v_d, sk_v_q, sk_v_d;
  logic out_load, sk_load, arrive, out_free;
  res_t out_q, sk_q;

  assign ready_o  = !sk_v_q;
  assign arrive   = res_valid_i && ready_o;
  assign out_free = !out_v_q || res_o.ready;

  always_comb begin
    out_v_d  = out_v_q;
    sk_v_d   = sk_v_q;
    out_load = 1'b0;
    sk_load  = 1'b0;
    if (out_free) begin
      // skid entry is older than anything arriving (none arrives while full)
      out_v_d  = sk_v_q || arrive;
      out_load = 1'b1;
      sk_v_d   = 1'b0;
    end else if (arrive) begin
      sk_v_d  = 1'b1;
      sk_load = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      sk_v_q  <= sk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= sk_v_q ? sk_q : res_i;
    end
    if (sk_load) begin
      sk_q <= res_i;
    end
  end

  assign res_o.valid       = out_v_q;
  assign res_o.gray_level  = out_q.gray_level;
  assign res_o.was_clipped = out_q.was_clipped;

endmodule

>>> hw/rtl/luma_gamma_correction.sv
// ----------------------------------------------------------------------------
// Luma gamma correction - top level
// Gray level = (0.3 R + 0.59 G + 0.11 B) ^ gamma, truncated, saturated at 255.
//
//   channel  dir  handshake         payload
//   pix_i    in   valid / ready     blue, green, red (8 b each)
//   res_o    out  valid / ready     gray_level (8 b), was_clipped
//   cfg      in   cfg_we_i          cfg_wdata_i: gamma, unsigned Q4.12
//
// One item per clock while the skid entry is free. Acceptance to res_o.valid:
// 3 front stages, 31 log2 stages, 33 power/exp2 stages, output register.
// All stages advance together while the skid entry is free; a stalled sink
// fills the skid entry and then holds the pipeline, nothing is dropped.
// Reset clears valid bits and loads gamma with 4506 (about 1.1).
// ----------------------------------------------------------------------------
`include "luma_gamma_correction_defines.svh"

module luma_gamma_correction #(
  parameter int unsigned FRACTION_BITS = lgc_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lgc_pix_if.sink                     pix_i,
  lgc_res_if.source                   res_o,
  input  logic                        cfg_we_i,
  input  logic [lgc_pkg::GAMMA_W-1:0] cfg_wdata_i
);
  import lgc_pkg::*;

  logic [GAMMA_W-1:0] gamma_q;
  logic               en;
  logic               front_v, log_v, last_v;
  norm_t              norm;
  log_t               log_w;
  res_t               res_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GAMMA_RST;
    end else if (cfg_we_i) begin
      gamma_q <= cfg_wdata_i;
    end
  end

  lgc_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .pix_i   (pix_i),
    .valid_o (front_v),
    .norm_o  (norm)
  );

  lgc_log2 #(.FRACTION_BITS(FRACTION_BITS)) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_v),
    .norm_i  (norm),
    .valid_o (log_v),
    .log_o   (log_w)
  );

  lgc_exp2 #(.FRACTION_BITS(FRACTION_BITS)) u_exp2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .gamma_i (gamma_q),
    .valid_i (log_v),
    .log_i   (log_w),
    .valid_o (last_v),
    .res_o   (res_w)
  );

  lgc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (last_v),
    .res_i       (res_w),
    .ready_o     (en),
    .res_o       (res_o)
  );

  `LGC_ASSERT_SAME(a_stall_needs_output, !pix_i.ready, res_o.valid,
                   "pipeline held with empty output")
  `LGC_ASSERT_SAME(a_clip_saturates, res_o.valid && res_o.was_clipped,
                   res_o.gray_level == GRAY_MAX, "clipped item not at 255")
  `LGC_ASSERT_NEXT(a_stall_fills_skid,
                   res_o.valid && !res_o.ready && last_v && pix_i.ready,
                   !pix_i.ready, "arriving item not parked on stall")

endmodule
